>>> rtl/kwm_pkg.sv
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int LISTS      = 8;
  localparam int LIST_DEPTH = 8;

  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 3;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int LIST_W  = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
  localparam int ENTRIES = LISTS * LIST_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int REM_W   = $clog2(ENTRIES + 1);

  localparam logic [OP_W-1:0] OP_APPEND       = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_MERGE = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE        = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE         = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_MERGED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic                      do_append;
    logic                      do_merge;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          src;
    logic [STATUS_W-1:0]       status;
    logic                      last;
  } res_t;

endpackage

>>> rtl/kwm_front.sv
`timescale 1ns / 1ps

module kwm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic [kwm_pkg::OP_W-1:0]          operation_i,
  input  logic [kwm_pkg::IDX_W-1:0]         list_index_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0] value_i,
  output logic                              full_o,
  output logic                              cmd_valid_o,
  output kwm_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_ready_i
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = 1;
  localparam int CNT_W  = 2;

  kwm_pkg::cmd_t q_mem [QDEPTH];
  kwm_pkg::cmd_t cmd_in;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  // Operation code 3 is accepted and discarded here.
  always_comb begin
    cmd_in.do_append = (operation_i == kwm_pkg::OP_APPEND) ||
                       (operation_i == kwm_pkg::OP_APPEND_MERGE);
    cmd_in.do_merge  = (operation_i == kwm_pkg::OP_APPEND_MERGE) ||
                       (operation_i == kwm_pkg::OP_MERGE);
    cmd_in.idx       = list_index_i;
    cmd_in.value     = value_i;
  end

  assign full_o      = (cnt_q == CNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_en       = push_i && !full_o && (operation_i != kwm_pkg::OP_NONE);
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/kwm_back.sv
`timescale 1ns / 1ps

module kwm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  kwm_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output kwm_pkg::res_t res_o,
  input  logic          res_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEL  = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  logic [1:0] state_q, state_d;

  logic [kwm_pkg::FILL_W-1:0] fill_q [kwm_pkg::LISTS];
  logic [kwm_pkg::FILL_W-1:0] fill_d [kwm_pkg::LISTS];
  logic [kwm_pkg::FILL_W-1:0] head_q [kwm_pkg::LISTS];
  logic [kwm_pkg::FILL_W-1:0] head_d [kwm_pkg::LISTS];
  logic [kwm_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [kwm_pkg::LIST_W-1:0] win_q, win_d;
  logic                       refill_q, refill_d;

  logic signed [kwm_pkg::VALUE_W-1:0] headval_q [kwm_pkg::LISTS];
  logic signed [kwm_pkg::VALUE_W-1:0] tail_q [kwm_pkg::LISTS];
  logic signed [kwm_pkg::VALUE_W-1:0] mem [kwm_pkg::ENTRIES];
  logic signed [kwm_pkg::VALUE_W-1:0] rd_data_q;

  logic                         idx_ok;
  logic [kwm_pkg::LIST_W-1:0]   li;
  logic [kwm_pkg::FILL_W-1:0]   cur_fill;
  logic                         app_err;
  logic [kwm_pkg::STATUS_W-1:0] err_status;
  logic                         wr_en, rd_en;
  logic [kwm_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
  logic [kwm_pkg::FILL_W-1:0]   next_head;

  logic                               found;
  logic [kwm_pkg::LIST_W-1:0]         best;
  logic signed [kwm_pkg::VALUE_W-1:0] bv;

  assign idx_ok   = int'(cmd_i.idx) < kwm_pkg::LISTS;
  assign li       = kwm_pkg::LIST_W'(cmd_i.idx);
  assign cur_fill = fill_q[li];
  assign wr_addr  = kwm_pkg::ADDR_W'(li) * kwm_pkg::ADDR_W'(kwm_pkg::LIST_DEPTH) +
                    kwm_pkg::ADDR_W'(cur_fill);

  always_comb begin
    app_err    = 1'b1;
    err_status = kwm_pkg::STATUS_FULL;
    if (idx_ok && (int'(cur_fill) < kwm_pkg::LIST_DEPTH)) begin
      if ((cur_fill != '0) && (cmd_i.value < tail_q[li])) begin
        err_status = kwm_pkg::STATUS_ORDER;
      end else begin
        app_err = 1'b0;
      end
    end
  end

  // On equal values the later list wins, so the scan keeps replacing on a tie.
  always_comb begin
    found = 1'b0;
    best  = '0;
    bv    = '0;
    for (int i = 0; i < kwm_pkg::LISTS; i++) begin
      if ((head_q[i] < fill_q[i]) && (!found || !(bv < headval_q[i]))) begin
        found = 1'b1;
        best  = kwm_pkg::LIST_W'(i);
        bv    = headval_q[i];
      end
    end
  end

  assign next_head = head_q[best] + kwm_pkg::FILL_W'(1);
  assign rd_addr   = kwm_pkg::ADDR_W'(best) * kwm_pkg::ADDR_W'(kwm_pkg::LIST_DEPTH) +
                     kwm_pkg::ADDR_W'(next_head);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    head_d      = head_q;
    rem_d       = rem_q;
    win_d       = win_q;
    refill_d    = refill_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.do_append) begin
            if (app_err) begin
              res_o.value  = cmd_i.value;
              res_o.src    = cmd_i.idx;
              res_o.status = err_status;
              res_o.last   = 1'b1;
              if (res_ready_i) begin
                res_valid_o = 1'b1;
                cmd_ready_o = 1'b1;
              end
            end else begin
              cmd_ready_o = 1'b1;
              wr_en       = 1'b1;
              fill_d[li]  = cur_fill + kwm_pkg::FILL_W'(1);
              rem_d       = rem_q + kwm_pkg::REM_W'(1);
              if (cmd_i.do_merge) begin
                state_d = ST_SEL;
              end
            end
          end else begin
            cmd_ready_o = 1'b1;
            state_d     = ST_SEL;
          end
        end
      end
      ST_SEL: begin
        if (rem_q == '0) begin
          res_o.status = kwm_pkg::STATUS_EMPTY;
          res_o.last   = 1'b1;
          if (res_ready_i) begin
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          res_o.value  = bv;
          res_o.src    = kwm_pkg::IDX_W'(best);
          res_o.status = kwm_pkg::STATUS_MERGED;
          res_o.last   = (rem_q == kwm_pkg::REM_W'(1));
          if (res_ready_i) begin
            res_valid_o = 1'b1;
            if (rem_q == kwm_pkg::REM_W'(1)) begin
              rem_d = '0;
              for (int i = 0; i < kwm_pkg::LISTS; i++) begin
                fill_d[i] = '0;
                head_d[i] = '0;
              end
              state_d = ST_IDLE;
            end else begin
              head_d[best] = next_head;
              rem_d        = rem_q - kwm_pkg::REM_W'(1);
              win_d        = best;
              refill_d     = next_head < fill_q[best];
              rd_en        = next_head < fill_q[best];
              state_d      = ST_FILL;
            end
          end
        end
      end
      ST_FILL: begin
        state_d = ST_SEL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rem_q    <= '0;
      win_q    <= '0;
      refill_q <= 1'b0;
      for (int i = 0; i < kwm_pkg::LISTS; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rem_q    <= rem_d;
      win_q    <= win_d;
      refill_q <= refill_d;
      fill_q   <= fill_d;
      head_q   <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
      tail_q[li]   <= cmd_i.value;
      if (cur_fill == '0) begin
        headval_q[li] <= cmd_i.value;
      end
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if ((state_q == ST_FILL) && refill_q) begin
      headval_q[win_q] <= rd_data_q;
    end
  end

endmodule

>>> rtl/kwm_res_q.sv
`timescale 1ns / 1ps

module kwm_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kwm_pkg::res_t res_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          empty_o,
  output kwm_pkg::res_t res_o
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = 1;
  localparam int CNT_W  = 2;

  kwm_pkg::res_t q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = q_mem[rd_ptr_q];
  assign wr_en   = push_i && ready_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

>>> rtl/k_way_sorted_merge.sv
`timescale 1ns / 1ps

// Merges up to eight sorted lists of signed 32-bit values into one nondecreasing
// stream of words. Input words pass through a two-entry command queue, so the
// input side can take up to two words while the merge engine is busy. A plain
// append goes straight into its list, and an append that is dropped waits until
// the two-entry result queue has room. For each stored value a merge first picks
// the smallest head value across the lists, then refills that list's head
// register from the single read port of the element RAM. The last value needs no
// refill, and an empty merge gives one word of status empty.

module k_way_sorted_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [kwm_pkg::OP_W-1:0]           operation_i,
  input  logic [kwm_pkg::IDX_W-1:0]          list_index_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0] value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [kwm_pkg::VALUE_W-1:0] merged_value_o,
  output logic [kwm_pkg::IDX_W-1:0]          source_list_o,
  output logic [kwm_pkg::STATUS_W-1:0]       status_o,
  output logic                               last_o
);

  kwm_pkg::cmd_t cmd;
  kwm_pkg::res_t res_in, res_out;
  logic          cmd_valid, cmd_ready;
  logic          res_valid, res_ready;

  kwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .operation_i  (operation_i),
    .list_index_i (list_index_i),
    .value_i      (value_i),
    .full_o       (full),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  kwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res_in),
    .res_ready_i (res_ready)
  );

  kwm_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res_in),
    .ready_o (res_ready),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign merged_value_o = res_out.value;
  assign source_list_o  = res_out.src;
  assign status_o       = res_out.status;
  assign last_o         = res_out.last;

endmodule

>>> verif/k_way_sorted_merge_test.sv
`timescale 1ns / 1ps

module k_way_sorted_merge_test;
  import kwm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 48;
  localparam int MAX_REPORTS = 40;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic [OP_W-1:0]           operation_i;
  logic [IDX_W-1:0]          list_index_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      empty;
  logic                      pop;
  logic signed [VALUE_W-1:0] merged_value_o;
  logic [IDX_W-1:0]          source_list_o;
  logic [STATUS_W-1:0]       status_o;
  logic                      last_o;

  logic signed [VALUE_W-1:0] list_store [LISTS][LIST_DEPTH];
  int                        list_count [LISTS];
  res_t                      expected_words [$];
  res_t                      checked_word;
  int                        errors;
  int                        items_sent;
  bit                        no_idle;

  k_way_sorted_merge uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .list_index_i   (list_index_i),
    .value_i        (value_i),
    .empty          (empty),
    .pop            (pop),
    .merged_value_o (merged_value_o),
    .source_list_o  (source_list_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic queue_expected(input res_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic predict_merge_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                    input logic signed [VALUE_W-1:0] val);
    logic [STATUS_W-1:0]       err;
    logic signed [VALUE_W-1:0] best_value;
    int                        head [LISTS];
    int                        total;
    int                        best;
    res_t                      w;
    if (op == OP_NONE) return;
    if (op != OP_MERGE) begin
      err = STATUS_MERGED;
      if (idx >= LISTS || list_count[idx] >= LIST_DEPTH) begin
        err = STATUS_FULL;
      end else if (list_count[idx] > 0 && val < list_store[idx][list_count[idx] - 1]) begin
        err = STATUS_ORDER;
      end
      if (err != STATUS_MERGED) begin
        w.value  = val;
        w.src    = idx;
        w.status = err;
        w.last   = 1'b1;
        queue_expected(w);
        return;
      end
      list_store[idx][list_count[idx]] = val;
      list_count[idx]++;
      if (op == OP_APPEND) return;
    end
    total = 0;
    for (int i = 0; i < LISTS; i++) begin
      total += list_count[i];
      head[i] = 0;
    end
    if (total == 0) begin
      w.value  = '0;
      w.src    = '0;
      w.status = STATUS_EMPTY;
      w.last   = 1'b1;
      queue_expected(w);
      return;
    end
    for (int k = 0; k < total; k++) begin
      best = -1;
      best_value = '0;
      for (int i = 0; i < LISTS; i++) begin
        if (head[i] < list_count[i]) begin
          if (best < 0 || !(best_value < list_store[i][head[i]])) begin
            best = i;
            best_value = list_store[i][head[i]];
          end
        end
      end
      head[best]++;
      w.value  = best_value;
      w.src    = best[IDX_W-1:0];
      w.status = STATUS_MERGED;
      w.last   = (k == total - 1);
      queue_expected(w);
    end
    for (int i = 0; i < LISTS; i++) list_count[i] = 0;
  endtask

  function automatic logic signed [VALUE_W-1:0] sorted_value(input int idx, input bit narrow);
    longint                    nv;
    logic signed [VALUE_W-1:0] prev;
    if (list_count[idx] == 0) begin
      if (narrow) nv = longint'($urandom_range(0, 8)) - 4;
      else nv = longint'($signed($urandom));
    end else begin
      prev = list_store[idx][list_count[idx] - 1];
      if (narrow) nv = longint'(prev) + longint'($urandom_range(0, 2));
      else if ($urandom_range(0, 3) == 0) nv = longint'(prev);
      else nv = longint'(prev) + longint'($urandom_range(0, 1 << 20));
    end
    if (nv > longint'(VAL_MAX)) nv = longint'(VAL_MAX);
    return nv[VALUE_W-1:0];
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    operation_i  <= op;
    list_index_i <= idx;
    value_i      <= val;
    do @(posedge clk_i); while (full);
    predict_merge_word(op, idx, val);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic test_empty_merge();
    send_word(OP_MERGE, 3'd0, '0);
    send_word(OP_NONE, 3'd7, -1);
    send_word(OP_MERGE, 3'd5, 32'sh5A5A5A5A);
  endtask

  task automatic test_extremes_and_ties();
    send_word(OP_APPEND, 3'd0, VAL_MIN);
    send_word(OP_APPEND, 3'd0, VAL_MIN);
    send_word(OP_APPEND, 3'd7, VAL_MAX);
    send_word(OP_APPEND, 3'd3, -1);
    send_word(OP_APPEND, 3'd3, 0);
    send_word(OP_APPEND, 3'd5, 0);
    send_word(OP_APPEND, 3'd3, -5);
    send_word(OP_APPEND, 3'd6, VAL_MAX);
    send_word(OP_APPEND_MERGE, 3'd7, 0);
    send_word(OP_APPEND_MERGE, 3'd2, 0);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++) send_word(OP_APPEND, 3'd4, 32'sh3C3C0000 + i);
    send_word(OP_APPEND, 3'd4, VAL_MAX);
    send_word(OP_APPEND_MERGE, 3'd4, VAL_MAX);
    send_word(OP_APPEND, 3'd1, -7);
    send_word(OP_MERGE, 3'd0, '0);
  endtask

  task automatic test_random_batches(input int target);
    int  n;
    int  pick;
    int  idx;
    bit  narrow;
    while (items_sent < target) begin
      n = $urandom_range(1, 20);
      narrow = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < n; j++) begin
        pick = $urandom_range(0, 19);
        idx = $urandom_range(0, LISTS - 1);
        if (pick < 16) send_word(OP_APPEND, IDX_W'(idx), sorted_value(idx, narrow));
        else if (pick < 18) send_word(OP_APPEND, IDX_W'(idx), $signed($urandom));
        else if (pick == 18) send_word(OP_NONE, IDX_W'($urandom), $urandom);
        else send_word(OP_MERGE, IDX_W'($urandom), $urandom);
      end
      idx = $urandom_range(0, LISTS - 1);
      if ($urandom_range(0, 1) == 0) begin
        send_word(OP_APPEND_MERGE, IDX_W'(idx), sorted_value(idx, narrow));
      end else begin
        send_word(OP_MERGE, IDX_W'(idx), $urandom);
      end
    end
  endtask

  task automatic test_full_store(input bit narrow);
    int idx;
    send_word(OP_MERGE, IDX_W'($urandom), $urandom);
    for (int k = 0; k < ENTRIES; ) begin
      idx = $urandom_range(0, LISTS - 1);
      if (list_count[idx] < LIST_DEPTH) begin
        send_word(OP_APPEND, IDX_W'(idx), sorted_value(idx, narrow));
        k++;
      end
    end
    send_word(OP_APPEND, IDX_W'($urandom), $urandom);
    send_word(OP_APPEND_MERGE, IDX_W'($urandom), $urandom);
    send_word(OP_MERGE, IDX_W'($urandom), $urandom);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_batches(items_sent + 15);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (no_idle) begin
        stall_left = 0;
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected word value %0d src %0d status %0d last %0d", $time,
                   merged_value_o, source_list_o, status_o, last_o);
        end
      end else begin
        checked_word = expected_words.pop_front();
        if (merged_value_o !== checked_word.value || source_list_o !== checked_word.src ||
            status_o !== checked_word.status || last_o !== checked_word.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display({"%0t: expected value %0d src %0d status %0d last %0d, ",
                      "got value %0d src %0d status %0d last %0d"},
                     $time, checked_word.value, checked_word.src, checked_word.status,
                     checked_word.last, merged_value_o, source_list_o, status_o, last_o);
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    operation_i  = OP_NONE;
    list_index_i = '0;
    value_i      = '0;
    errors       = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    for (int i = 0; i < LISTS; i++) list_count[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_merge();
    test_extremes_and_ties();
    test_full_list();
    test_random_batches(items_sent + 30);
    test_full_store(1'b1);
    test_full_store(1'b0);
    test_back_to_back();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
